/* rtl/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants for the timed pulse sequencer.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int TIME_W  = 24;
   localparam int INDEX_W = 8;
   localparam int PLAY_W  = 9;
   localparam int WORD_W  = 32;

   localparam logic [7:0] OP_WRITE_ENTRY = 8'h01;
   localparam logic [7:0] OP_SET_FINAL   = 8'h02;
   localparam logic [7:0] OP_SET_REPEAT  = 8'h03;
   localparam logic [7:0] OP_SET_MODE    = 8'h04;
   localparam logic [7:0] OP_RUN         = 8'h05;
   localparam logic [7:0] OP_ARM         = 8'h06;
   localparam logic [7:0] OP_STOP        = 8'h07;
   localparam logic [7:0] OP_READ_TIME   = 8'h08;
   localparam logic [7:0] OP_FIRMWARE    = 8'hFD;
   localparam logic [7:0] OP_HARD_RESET  = 8'hFF;

   localparam logic [7:0]        FIRMWARE_VER   = 8'h06;
   localparam logic [WORD_W-1:0] TRIGGER_OFFSET = 32'h0000_0400;
   localparam logic [TIME_W-1:0] HALF_RANGE     = 24'h80_0000;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_FW   = 3'd2;
   localparam logic [2:0] LEN_TIME = 3'd3;
   localparam logic [2:0] LEN_ARM  = 3'd4;

   typedef enum logic [1:0] {
      ST_INIT      = 2'd0,
      ST_READY     = 2'd1,
      ST_RUNNING   = 2'd2,
      ST_REPEATING = 2'd3
   } run_state_type;

   typedef enum logic [1:0] {
      CS_IDLE = 2'b01,
      CS_EXEC = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

endpackage

/* rtl/timed_pulse_sequencer.sv */
// ----------------------------------------------------------------------------
// timed_pulse_sequencer
// Pulse sequencer: entry table played into a pin driver, host commands and
// armed fire time.
// ----------------------------------------------------------------------------
// Each transaction has an accept cycle, which also issues the registered table
// read at the current play position, and an execute cycle that updates the
// sequencer state and loads the result register. A new
// transaction is accepted while a result still waits on the rsp side; only
// a full result register with rsp_ready low holds the execute cycle. The
// table comes out of reset cleared at once through per-entry valid bits, so
// there is no clearing pass. rsp_run_status shows the run state after the
// transaction whose result is presented.
// ----------------------------------------------------------------------------
module timed_pulse_sequencer #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [tps_pkg::TIME_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [7:0]                    req_opcode,
   input  logic [tps_pkg::INDEX_W-1:0]   req_index_arg,
   input  logic [7:0]                    req_pin_mask,
   input  logic [tps_pkg::TIME_W-1:0]    req_value_arg,
   input  logic                          req_repeat_on,
   input  logic [tps_pkg::TIME_W-1:0]    req_now_time,
   input  logic                          req_driver_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_resp_len,
   output logic [31:0]                   rsp_resp_data,
   output logic                          rsp_pin_valid,
   output logic [tps_pkg::WORD_W-1:0]    rsp_pin_word,
   output logic                          rsp_fired,
   output logic [1:0]                    rsp_run_status
);
   import tps_pkg::*;

   dp_cmd_type cmd;

   tps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   tps_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_type         (req_type),
      .req_opcode       (req_opcode),
      .req_index_arg    (req_index_arg),
      .req_pin_mask     (req_pin_mask),
      .req_value_arg    (req_value_arg),
      .req_repeat_on    (req_repeat_on),
      .req_now_time     (req_now_time),
      .req_driver_ready (req_driver_ready),
      .rsp_resp_len     (rsp_resp_len),
      .rsp_resp_data    (rsp_resp_data),
      .rsp_pin_valid    (rsp_pin_valid),
      .rsp_pin_word     (rsp_pin_word),
      .rsp_fired        (rsp_fired),
      .rsp_run_status   (rsp_run_status)
   );

endmodule

/* rtl/tps_ctrl.sv */
// ----------------------------------------------------------------------------
// tps_ctrl
// Handshake controller: accepts a transaction, runs its execute cycle and
// holds the result register valid until the consumer takes it.
// ----------------------------------------------------------------------------
module tps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tps_pkg::dp_cmd_type cmd
);
   import tps_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == CS_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CS_EXEC;
            end
         end
         CS_EXEC: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/tps_datapath.sv */
// ----------------------------------------------------------------------------
// tps_datapath
// Sequencer state, entry table, fire check, command decode and result
// register.
// ----------------------------------------------------------------------------
module tps_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tps_pkg::dp_cmd_type                 cmd,
   input  logic                                csr_write_enable,
   input  logic [tps_pkg::TIME_W-1:0]          csr_write_data,
   input  logic                                req_type,
   input  logic [7:0]                          req_opcode,
   input  logic [tps_pkg::INDEX_W-1:0]         req_index_arg,
   input  logic [7:0]                          req_pin_mask,
   input  logic [tps_pkg::TIME_W-1:0]          req_value_arg,
   input  logic                                req_repeat_on,
   input  logic [tps_pkg::TIME_W-1:0]          req_now_time,
   input  logic                                req_driver_ready,
   output logic [2:0]                          rsp_resp_len,
   output logic [31:0]                         rsp_resp_data,
   output logic                                rsp_pin_valid,
   output logic [tps_pkg::WORD_W-1:0]          rsp_pin_word,
   output logic                                rsp_fired,
   output logic [1:0]                          rsp_run_status
);
   import tps_pkg::*;

   localparam int                IDX_W   = $clog2(TABLE_DEPTH);
   localparam logic [PLAY_W-1:0] DEPTH_P = PLAY_W'(TABLE_DEPTH);

   // captured request
   logic                type_ff;
   logic [7:0]          op_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [7:0]          mask_ff;
   logic [TIME_W-1:0]   val_ff;
   logic                rep_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                rdy_ff;

   // sequencer state
   logic [TIME_W-1:0]   window_ff;
   logic [INDEX_W-1:0]  final_ff, final_in;
   logic [PLAY_W-1:0]   play_ff, play_in;
   logic [INDEX_W-1:0]  repeat_ff, repeat_in;
   logic [TIME_W-1:0]   fire_time_ff, fire_time_in;
   logic                armed_ff, armed_in;
   run_state_type       run_ff, run_in;
   logic [TIME_W-1:0]   last_ff, last_in;

   // entry table
   logic [WORD_W-1:0]      mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [WORD_W-1:0]      mem_rd_ff;
   logic                   rd_ok_ff;
   logic                   wr_en;
   logic [WORD_W-1:0]      entry;

   // result
   logic [2:0]          len_in,   len_ff;
   logic [31:0]         data_in,  data_ff;
   logic                pvalid_in, pvalid_ff;
   logic [WORD_W-1:0]   pword_in, pword_ff;
   logic                fired_in, fired_ff;

   logic [TIME_W-1:0]   delta;
   logic [TIME_W-1:0]   back;
   logic                future;

   assign entry  = rd_ok_ff ? mem_rd_ff : '0;
   assign delta  = fire_time_ff - now_ff;
   assign back   = now_ff - val_ff;
   assign future = !((back != '0) && (back <= HALF_RANGE));
   assign wr_en  = cmd.commit && !type_ff && (op_ff == OP_WRITE_ENTRY) &&
                   ({1'b0, idx_ff} < DEPTH_P);

   always_comb begin
      final_in     = final_ff;
      play_in      = play_ff;
      repeat_in    = repeat_ff;
      fire_time_in = fire_time_ff;
      armed_in     = armed_ff;
      run_in       = run_ff;
      last_in      = last_ff;
      len_in       = LEN_NONE;
      data_in      = '0;
      pvalid_in    = 1'b0;
      pword_in     = '0;
      fired_in     = 1'b0;
      if (type_ff) begin
         last_in = now_ff;
         if (armed_ff && (run_ff != ST_RUNNING) && (delta != '0) &&
             (delta <= window_ff)) begin
            run_in       = ST_RUNNING;
            play_in      = '0;
            fire_time_in = '0;
            armed_in     = 1'b0;
            fired_in     = 1'b1;
         end else if (((run_ff == ST_RUNNING) || (run_ff == ST_REPEATING)) && rdy_ff) begin
            if (play_ff <= {1'b0, final_ff}) begin
               pvalid_in = 1'b1;
               pword_in  = entry - TRIGGER_OFFSET;
               play_in   = play_ff + PLAY_W'(1);
            end else if (run_ff == ST_RUNNING) begin
               play_in = '0;
               run_in  = ST_READY;
            end else begin
               play_in = {1'b0, repeat_ff};
            end
         end
      end else begin
         case (op_ff)
            OP_SET_FINAL: begin
               final_in = idx_ff;
            end
            OP_SET_REPEAT: begin
               if (idx_ff < final_ff) begin
                  repeat_in = idx_ff;
               end else if (final_ff == '0) begin
                  repeat_in = '0;
               end else begin
                  repeat_in = final_ff - INDEX_W'(1);
               end
            end
            OP_SET_MODE: begin
               run_in    = rep_ff ? ST_REPEATING : ST_READY;
               repeat_in = '0;
            end
            OP_RUN: begin
               run_in  = ST_RUNNING;
               play_in = '0;
               len_in  = LEN_TIME;
               data_in = {8'h00, last_ff};
            end
            OP_ARM: begin
               last_in = now_ff;
               if (future) begin
                  fire_time_in = val_ff;
                  armed_in     = 1'b1;
               end
               len_in  = LEN_ARM;
               data_in = {7'b0, future, now_ff};
            end
            OP_STOP: begin
               run_in  = ST_READY;
               play_in = {1'b0, repeat_ff};
            end
            OP_READ_TIME: begin
               last_in = now_ff;
               len_in  = LEN_TIME;
               data_in = {8'h00, now_ff};
            end
            OP_FIRMWARE: begin
               len_in  = LEN_FW;
               data_in = {16'h0000, FIRMWARE_VER, FIRMWARE_VER};
            end
            OP_HARD_RESET: begin
               run_in = ST_INIT;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff   <= req_type;
         op_ff     <= req_opcode;
         idx_ff    <= req_index_arg;
         mask_ff   <= req_pin_mask;
         val_ff    <= req_value_arg;
         rep_ff    <= req_repeat_on;
         now_ff    <= req_now_time;
         rdy_ff    <= req_driver_ready;
         mem_rd_ff <= mem[play_ff[IDX_W-1:0]];
      end
      if (wr_en) begin
         mem[idx_ff[IDX_W-1:0]] <= {val_ff, mask_ff};
      end
      if (cmd.commit) begin
         len_ff    <= len_in;
         data_ff   <= data_in;
         pvalid_ff <= pvalid_in;
         pword_ff  <= pword_in;
         fired_ff  <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         window_ff    <= TIME_W'(1);
         final_ff     <= '0;
         play_ff      <= '0;
         repeat_ff    <= '0;
         fire_time_ff <= '0;
         armed_ff     <= 1'b0;
         run_ff       <= ST_INIT;
         last_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         if (cmd.capture) begin
            rd_ok_ff <= (play_ff < DEPTH_P) && valid_ff[play_ff[IDX_W-1:0]];
         end
         if (wr_en) begin
            valid_ff[idx_ff[IDX_W-1:0]] <= 1'b1;
         end
         if (cmd.commit) begin
            final_ff     <= final_in;
            play_ff      <= play_in;
            repeat_ff    <= repeat_in;
            fire_time_ff <= fire_time_in;
            armed_ff     <= armed_in;
            run_ff       <= run_in;
            last_ff      <= last_in;
         end
      end
   end

   assign rsp_resp_len   = len_ff;
   assign rsp_resp_data  = data_ff;
   assign rsp_pin_valid  = pvalid_ff;
   assign rsp_pin_word   = pword_ff;
   assign rsp_fired      = fired_ff;
   assign rsp_run_status = run_ff;

endmodule

/* dv/tb_timed_pulse_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_timed_pulse_sequencer
// Self-checking bench for the timed pulse sequencer. A short table of
// directed transactions walks through every command, table extremes, arming
// and firing. Random traffic follows: mostly poll ticks with an advancing
// clock, mixed with entry writes, run control and arming. Each phase uses
// another fire window. Every result is checked field by field, against fixed
// values for some directed rows, else against a predictor that tracks the table
// and run state. Both channels stall at random; one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_timed_pulse_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import tps_pkg::*;

   localparam int HALF_PERIOD     = 2;
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int STALL_LIMIT     = 1000;
   localparam int LONG_HOLD       = 80;
   localparam int MAX_REPORTS     = 40;

   localparam logic [7:0] OP_UNUSED = 8'h00;

   typedef struct {
      logic                req_type;
      logic [7:0]          opcode;
      logic [INDEX_W-1:0]  index_arg;
      logic [7:0]          pin_mask;
      logic [TIME_W-1:0]   value_arg;
      logic                repeat_on;
      logic [TIME_W-1:0]   now_time;
      logic                driver_ready;
   } seq_item_type;

   typedef struct {
      logic [2:0]          resp_len;
      logic [31:0]         resp_data;
      logic                pin_valid;
      logic [WORD_W-1:0]   pin_word;
      logic                fired;
      run_state_type       run_status;
   } seq_result_type;

   typedef struct {
      seq_item_type        item;
      logic                fixed;
      seq_result_type      want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [TIME_W-1:0]   csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_type = 1'b0;
   logic [7:0]          req_opcode = '0;
   logic [INDEX_W-1:0]  req_index_arg = '0;
   logic [7:0]          req_pin_mask = '0;
   logic [TIME_W-1:0]   req_value_arg = '0;
   logic                req_repeat_on = 1'b0;
   logic [TIME_W-1:0]   req_now_time = '0;
   logic                req_driver_ready = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [2:0]          rsp_resp_len;
   logic [31:0]         rsp_resp_data;
   logic                rsp_pin_valid;
   logic [WORD_W-1:0]   rsp_pin_word;
   logic                rsp_fired;
   logic [1:0]          rsp_run_status;

   timed_pulse_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_opcode       (req_opcode),
      .req_index_arg    (req_index_arg),
      .req_pin_mask     (req_pin_mask),
      .req_value_arg    (req_value_arg),
      .req_repeat_on    (req_repeat_on),
      .req_now_time     (req_now_time),
      .req_driver_ready (req_driver_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_resp_len     (rsp_resp_len),
      .rsp_resp_data    (rsp_resp_data),
      .rsp_pin_valid    (rsp_pin_valid),
      .rsp_pin_word     (rsp_pin_word),
      .rsp_fired        (rsp_fired),
      .rsp_run_status   (rsp_run_status)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state
   logic [WORD_W-1:0]   pulse_table [256];
   logic [INDEX_W-1:0]  end_index;
   logic [PLAY_W-1:0]   play_pos;
   logic [INDEX_W-1:0]  loop_index;
   logic [TIME_W-1:0]   armed_time;
   logic                armed;
   run_state_type       seq_state;
   logic [TIME_W-1:0]   seen_time;
   logic [TIME_W-1:0]   window;

   seq_result_type      pending_results [$];
   stim_row_type        directed_rows [$];
   logic [TIME_W-1:0]   stim_clock = '0;
   logic                quiet = 1'b0;
   logic                long_hold_request = 1'b0;
   int                  rsp_stall_left = 0;
   int                  error_count = 0;
   int                  stall_cycles = 0;

   function automatic void model_reset();
      foreach (pulse_table[k]) pulse_table[k] = '0;
      end_index  = '0;
      play_pos   = '0;
      loop_index = '0;
      armed_time = '0;
      armed      = 1'b0;
      seq_state  = ST_INIT;
      seen_time  = '0;
      window     = 24'd1;
   endfunction

   function automatic seq_result_type sequencer_step(seq_item_type c);
      seq_result_type    r;
      logic [TIME_W-1:0] delta;
      logic [TIME_W-1:0] back;
      logic              fut;
      r.resp_len  = LEN_NONE;
      r.resp_data = '0;
      r.pin_valid = 1'b0;
      r.pin_word  = '0;
      r.fired     = 1'b0;
      if (c.req_type) begin
         seen_time = c.now_time;
         delta = armed_time - c.now_time;
         if (armed && seq_state != ST_RUNNING && delta != '0 && delta <= window) begin
            seq_state  = ST_RUNNING;
            play_pos   = '0;
            armed_time = '0;
            armed      = 1'b0;
            r.fired    = 1'b1;
         end else if ((seq_state == ST_RUNNING || seq_state == ST_REPEATING)
                      && c.driver_ready) begin
            if (play_pos <= {1'b0, end_index}) begin
               r.pin_valid = 1'b1;
               r.pin_word  = pulse_table[play_pos[7:0]] - TRIGGER_OFFSET;
               play_pos    = play_pos + 9'd1;
            end else if (seq_state == ST_RUNNING) begin
               play_pos  = '0;
               seq_state = ST_READY;
            end else begin
               play_pos = {1'b0, loop_index};
            end
         end
      end else begin
         case (c.opcode)
            OP_WRITE_ENTRY: begin
               pulse_table[c.index_arg] = {c.value_arg, c.pin_mask};
            end
            OP_SET_FINAL: begin
               end_index = c.index_arg;
            end
            OP_SET_REPEAT: begin
               if (c.index_arg < end_index) loop_index = c.index_arg;
               else if (end_index == '0) loop_index = '0;
               else loop_index = end_index - 8'd1;
            end
            OP_SET_MODE: begin
               if (c.repeat_on) seq_state = ST_REPEATING;
               else seq_state = ST_READY;
               loop_index = '0;
            end
            OP_RUN: begin
               seq_state   = ST_RUNNING;
               play_pos    = '0;
               r.resp_len  = LEN_TIME;
               r.resp_data = {8'd0, seen_time};
            end
            OP_ARM: begin
               seen_time = c.now_time;
               back = c.now_time - c.value_arg;
               fut = !(back >= 24'd1 && back <= HALF_RANGE);
               if (fut) begin
                  armed_time = c.value_arg;
                  armed      = 1'b1;
               end
               r.resp_len  = LEN_ARM;
               r.resp_data = {7'd0, fut, c.now_time};
            end
            OP_STOP: begin
               seq_state = ST_READY;
               play_pos  = {1'b0, loop_index};
            end
            OP_READ_TIME: begin
               seen_time   = c.now_time;
               r.resp_len  = LEN_TIME;
               r.resp_data = {8'd0, c.now_time};
            end
            OP_FIRMWARE: begin
               r.resp_len  = LEN_FW;
               r.resp_data = {16'd0, FIRMWARE_VER, FIRMWARE_VER};
            end
            OP_HARD_RESET: begin
               seq_state = ST_INIT;
            end
            default: ;
         endcase
      end
      r.run_status = seq_state;
      return r;
   endfunction

   function automatic seq_item_type host_cmd(logic [7:0] op, logic [7:0] idx, logic [7:0] mask,
                                             logic [23:0] val, logic rep, logic [23:0] now);
      seq_item_type c;
      c.req_type     = 1'b0;
      c.opcode       = op;
      c.index_arg    = idx;
      c.pin_mask     = mask;
      c.value_arg    = val;
      c.repeat_on    = rep;
      c.now_time     = now;
      c.driver_ready = 1'b0;
      return c;
   endfunction

   function automatic seq_item_type poll_tick(logic [23:0] now, logic rdy);
      seq_item_type c;
      c = host_cmd(OP_UNUSED, '0, '0, '0, 1'b0, now);
      c.req_type     = 1'b1;
      c.driver_ready = rdy;
      return c;
   endfunction

   function automatic stim_row_type fixed_row(seq_item_type c, logic [2:0] len,
                                              logic [31:0] data, logic fired,
                                              run_state_type st);
      stim_row_type row;
      row.item           = c;
      row.fixed          = 1'b1;
      row.want.resp_len  = len;
      row.want.resp_data = data;
      row.want.pin_valid = 1'b0;
      row.want.pin_word  = '0;
      row.want.fired     = fired;
      row.want.run_status = st;
      return row;
   endfunction

   function automatic stim_row_type free_row(seq_item_type c);
      stim_row_type row;
      row = fixed_row(c, LEN_NONE, '0, 1'b0, ST_INIT);
      row.fixed = 1'b0;
      return row;
   endfunction

   // mostly polls on an advancing clock, commands biased toward entry writes, arming and runs
   function automatic seq_item_type random_item();
      seq_item_type c;
      int           pick;
      c.opcode       = 8'($urandom);
      c.index_arg    = 8'($urandom);
      c.pin_mask     = 8'($urandom);
      c.value_arg    = 24'($urandom);
      c.repeat_on    = 1'($urandom);
      c.now_time     = 24'($urandom);
      c.driver_ready = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         c.req_type = 1'b1;
         if (pick == 0) stim_clock = 24'($urandom);
         else stim_clock = stim_clock + 24'($urandom_range(0, 2));
         c.now_time     = stim_clock;
         c.driver_ready = ($urandom_range(0, 7) != 0);
      end else begin
         c.req_type = 1'b0;
         case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
               c.opcode = OP_WRITE_ENTRY;
               if ($urandom_range(0, 3) != 0) c.index_arg = 8'($urandom_range(0, 15));
            end
            4: begin
               c.opcode = OP_SET_FINAL;
               if ($urandom_range(0, 7) == 0) c.index_arg = 8'hFF;
               else c.index_arg = 8'($urandom_range(0, 12));
            end
            5: begin
               c.opcode    = OP_SET_REPEAT;
               c.index_arg = 8'($urandom_range(0, 15));
            end
            6: c.opcode = OP_SET_MODE;
            7, 8: c.opcode = OP_RUN;
            9, 10, 11: begin
               c.opcode   = OP_ARM;
               c.now_time = stim_clock;
               case ($urandom_range(0, 3))
                  0, 1: c.value_arg = stim_clock + 24'($urandom_range(1, 6));
                  2: c.value_arg = stim_clock;
                  default: ;
               endcase
            end
            12: c.opcode = OP_STOP;
            13: begin
               c.opcode = OP_READ_TIME;
               if ($urandom_range(0, 1) == 0) c.now_time = stim_clock;
            end
            14: c.opcode = OP_FIRMWARE;
            15: c.opcode = OP_HARD_RESET;
            default: ;
         endcase
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t ns: %s mismatch, got %h expected %h", $realtime, what, got, want);
   endtask

   task automatic send_item(stim_row_type row);
      seq_result_type predicted;
      req_type         = row.item.req_type;
      req_opcode       = row.item.opcode;
      req_index_arg    = row.item.index_arg;
      req_pin_mask     = row.item.pin_mask;
      req_value_arg    = row.item.value_arg;
      req_repeat_on    = row.item.repeat_on;
      req_now_time     = row.item.now_time;
      req_driver_ready = row.item.driver_ready;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = sequencer_step(row.item);
      if (row.fixed) pending_results.push_back(row.want);
      else pending_results.push_back(predicted);
      @(negedge clock);
   endtask

   task automatic hold_off(int cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window(logic [TIME_W-1:0] value);
      csr_write_data   = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      window = value;
   endtask

   // receiver: short random stall bursts, one long hold-off on request
   always @(negedge clock) begin
      if (long_hold_request) begin
         long_hold_request = 1'b0;
         rsp_stall_left = LONG_HOLD;
      end
      if (rsp_stall_left != 0) begin
         rsp_ready = 1'b0;
         rsp_stall_left--;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         rsp_ready = 1'b0;
         rsp_stall_left = $urandom_range(0, 5);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      seq_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_resp_data, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_resp_len !== want.resp_len)
               report_mismatch("resp_len", 32'(rsp_resp_len), 32'(want.resp_len));
            if (rsp_resp_data !== want.resp_data)
               report_mismatch("resp_data", rsp_resp_data, want.resp_data);
            if (rsp_pin_valid !== want.pin_valid)
               report_mismatch("pin_valid", 32'(rsp_pin_valid), 32'(want.pin_valid));
            if (rsp_pin_word !== want.pin_word)
               report_mismatch("pin_word", rsp_pin_word, want.pin_word);
            if (rsp_fired !== want.fired)
               report_mismatch("fired", 32'(rsp_fired), 32'(want.fired));
            if (rsp_run_status !== want.run_status)
               report_mismatch("run_status", 32'(rsp_run_status), 32'(want.run_status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $realtime, STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [TIME_W-1:0] phase_window [PHASES];
      phase_window = '{24'd1, 24'd0, 24'hFF_FFFF, 24'd4, 24'd0};
      phase_window[PHASES-1] = 24'($urandom_range(5, 4000));
      model_reset();

      directed_rows.push_back(fixed_row(host_cmd(OP_FIRMWARE, '0, '0, '0, 1'b0, '0),
                                        LEN_FW, 32'h0000_0606, 1'b0, ST_INIT));
      directed_rows.push_back(fixed_row(host_cmd(OP_READ_TIME, '0, '0, '0, 1'b0, 24'hFF_FFFF),
                                        LEN_TIME, 32'h00FF_FFFF, 1'b0, ST_INIT));
      directed_rows.push_back(fixed_row(poll_tick(24'h00_0000, 1'b1),
                                        LEN_NONE, '0, 1'b0, ST_INIT));
      directed_rows.push_back(fixed_row(host_cmd(OP_WRITE_ENTRY, 8'd0, 8'hFF, 24'hFF_FFFF,
                                                 1'b0, '0), LEN_NONE, '0, 1'b0, ST_INIT));
      directed_rows.push_back(free_row(host_cmd(OP_WRITE_ENTRY, 8'd1, 8'h00, 24'h00_0000,
                                                1'b0, '0)));
      directed_rows.push_back(free_row(host_cmd(OP_WRITE_ENTRY, 8'd255, 8'h5A, 24'hA5_A5A5,
                                                1'b0, '0)));
      directed_rows.push_back(free_row(host_cmd(OP_WRITE_ENTRY, 8'd2, 8'h81, 24'h00_0400,
                                                1'b0, '0)));
      directed_rows.push_back(free_row(host_cmd(OP_SET_FINAL, 8'd2, '0, '0, 1'b0, '0)));
      // repeat-from past the end is clamped
      directed_rows.push_back(free_row(host_cmd(OP_SET_REPEAT, 8'd5, '0, '0, 1'b0, '0)));
      directed_rows.push_back(fixed_row(host_cmd(OP_RUN, '0, '0, '0, 1'b0, '0),
                                        LEN_TIME, '0, 1'b0, ST_RUNNING));
      directed_rows.push_back(free_row(poll_tick(24'd1, 1'b0)));
      for (int t = 2; t < 6; t++) directed_rows.push_back(free_row(poll_tick(24'(t), 1'b1)));
      directed_rows.push_back(free_row(host_cmd(OP_SET_MODE, '0, '0, '0, 1'b1, '0)));
      for (int t = 6; t < 10; t++) directed_rows.push_back(free_row(poll_tick(24'(t), 1'b1)));
      directed_rows.push_back(free_row(host_cmd(OP_STOP, '0, '0, '0, 1'b0, '0)));
      // exactly half a range back counts as past
      directed_rows.push_back(fixed_row(host_cmd(OP_ARM, '0, '0, 24'h80_0010, 1'b0, 24'h10),
                                        LEN_ARM, 32'h0000_0010, 1'b0, ST_READY));
      directed_rows.push_back(fixed_row(host_cmd(OP_ARM, '0, '0, 24'h00_0011, 1'b0, 24'h10),
                                        LEN_ARM, 32'h0100_0010, 1'b0, ST_READY));
      directed_rows.push_back(fixed_row(poll_tick(24'h00_0010, 1'b1),
                                        LEN_NONE, '0, 1'b1, ST_RUNNING));
      directed_rows.push_back(fixed_row(host_cmd(OP_HARD_RESET, '0, '0, '0, 1'b0, '0),
                                        LEN_NONE, '0, 1'b0, ST_INIT));
      directed_rows.push_back(fixed_row(host_cmd(OP_UNUSED, 8'hFF, 8'hFF, 24'hFF_FFFF, 1'b1,
                                                 24'hFF_FFFF), LEN_NONE, '0, 1'b0, ST_INIT));

      repeat (5) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k]) begin
         if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
         send_item(directed_rows[k]);
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_window(phase_window[p]);
         quiet = (p == PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 2 && n == 40) long_hold_request = 1'b1;
            if (p == 3 && n == 70) settle();
            if (!quiet && (n % 64) < 44 && $urandom_range(0, 4) == 0)
               hold_off($urandom_range(1, 6));
            send_item(free_row(random_item()));
         end
      end

      settle();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/tps_pkg.sv
rtl/tps_ctrl.sv
rtl/tps_datapath.sv
rtl/timed_pulse_sequencer.sv
dv/tb_timed_pulse_sequencer.sv
